/* design/tpmq_pkg.sv */
// Shared types, constants and helpers for the tree path-minimum block.
// Used by tree_path_minimum_query and the bench; depends on nothing.
package tpmq_pkg;

    localparam int MAX_NODES  = 1024;
    localparam int NODE_W     = 10;
    localparam int COUNT_W    = 11;
    localparam int LEVELS     = 11;
    localparam int LEVEL_W    = 4;
    localparam int LIFT_DEPTH = MAX_NODES * LEVELS;
    localparam int LIFT_AW    = 14;
    localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic                      op;
        logic [NODE_W-1:0]         parent_node;
        logic signed [31:0]        edge_weight;
        logic [NODE_W-1:0]         first_node;
        logic [NODE_W-1:0]         second_node;
    } t_in;

    typedef struct packed {
        logic signed [31:0] path_min;
        logic               no_edge;
        logic               error;
    } t_out;

    // one word per node
    typedef struct packed {
        logic [NODE_W-1:0]  parent;
        logic signed [31:0] weight;
        logic [COUNT_W-1:0] first_child;
        logic [COUNT_W-1:0] next_sibling;
        logic [NODE_W-1:0]  depth;
    } t_node;

    // one word per node and level
    typedef struct packed {
        logic [NODE_W-1:0]  anc;
        logic signed [31:0] mn;
    } t_lift;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_LD_P, S_LD_C, S_LD_W, S_LD_L,
        S_BR, S_EN_RD, S_EN_WB, S_LV_RD, S_LV_WR, S_WCHK, S_CL, S_UP, S_FIN,
        S_Q_RA, S_Q_RB, S_Q_SW, S_EQ_CK, S_EQ_UP, S_LC_RA, S_LC_RB, S_LC_UP,
        S_RES
    } t_state;

    function automatic logic [COUNT_W-1:0] clamp_count(logic [COUNT_W-1:0] v);
        if (v < COUNT_W'(2)) begin
            return COUNT_W'(2);
        end else if (v > COUNT_W'(MAX_NODES)) begin
            return COUNT_W'(MAX_NODES);
        end
        return v;
    endfunction

    function automatic logic [LIFT_AW-1:0] lift_addr(logic [NODE_W-1:0] node,
                                                     logic [LEVEL_W-1:0] lvl);
        return LIFT_AW'(node) * LIFT_AW'(LEVELS) + LIFT_AW'(lvl);
    endfunction

    function automatic logic signed [31:0] smin(logic signed [31:0] a,
                                                logic signed [31:0] b);
        return (a < b) ? a : b;
    endfunction

    // floor(log2(d)) for d > 0
    function automatic logic [LEVEL_W-1:0] top_bit(logic [NODE_W-1:0] d);
        logic [LEVEL_W-1:0] k;
        k = '0;
        for (int i = 0; i < NODE_W; i++) begin
            if (d[i]) begin
                k = LEVEL_W'(i);
            end
        end
        return k;
    endfunction

endpackage

/* design/tpmq_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; no package needed.
module tpmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* design/tree_path_minimum_query.sv */
// Tree path-minimum block: sequencer around a node memory and a lifting memory.
// Depends on tpmq_pkg and tpmq_ram.
//
// Usage: write node_count on i_cfg_we/i_cfg_data while idle, then send
// node_count-1 load transfers (op 0) for children 1, 2, ... in order. The last
// load starts a tree walk that fills the depth and binary-lifting tables.
// Query transfers (op 1) give one result each on the output channel; loads
// give none. The block takes one item at a time. A query reads the depths of
// both nodes, then makes depth-equalising jumps and a common-ancestor descent,
// each read going through the single lifting-memory port; error and same-node
// queries go straight to the result stage.
// Reset, a register write and a load after a finished tree all start a
// clearing pass over node_count node-memory words, one per cycle, during which
// no transfer is taken. A result waits in the output register while the
// receiver stalls; the next item is still taken, and its result holds until
// the register is free.
module tree_path_minimum_query (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [10:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  tpmq_pkg::t_in        i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output tpmq_pkg::t_out       o_out_data
);
    localparam int NW = tpmq_pkg::NODE_W;
    localparam int CW = tpmq_pkg::COUNT_W;
    localparam int KW = tpmq_pkg::LEVEL_W;

    tpmq_pkg::t_state r_state, n_state;
    logic [CW-1:0]  r_nc, n_nc;
    logic [NW-1:0]  r_edges, n_edges;
    logic           r_ready, n_ready, r_bad, n_bad, r_pend, n_pend, r_last, n_last;
    logic [NW-1:0]  r_cnt, n_cnt;
    tpmq_pkg::t_in   r_item, n_item;
    tpmq_pkg::t_node r_pword, n_pword, r_cw, n_cw;
    tpmq_pkg::t_lift r_tmp, n_tmp;
    logic [NW-1:0]  r_cur, n_cur, r_v, n_v, r_par, n_par, r_d, n_d;
    logic           r_root, n_root;
    logic [NW-1:0]  r_anc, n_anc;
    logic signed [31:0] r_mn, n_mn, r_ans, n_ans;
    logic [KW-1:0]  r_k, n_k;
    logic [CW-1:0]  r_seen, n_seen;
    logic [NW-1:0]  r_a, n_a, r_b, n_b, r_da, n_da, r_db, n_db;
    logic           r_fnone, n_fnone, r_ferr, n_ferr;
    tpmq_pkg::t_out r_out, n_out;
    logic           r_out_valid, n_out_valid;

    logic                          nd_we;
    logic [NW-1:0]                 nd_waddr, nd_raddr;
    tpmq_pkg::t_node               nd_wdata, nd_rd;
    logic [$bits(tpmq_pkg::t_node)-1:0] nd_rdata;
    logic                          lf_we;
    logic [tpmq_pkg::LIFT_AW-1:0]  lf_waddr, lf_raddr;
    tpmq_pkg::t_lift               lf_wdata, lf_rd;
    logic [$bits(tpmq_pkg::t_lift)-1:0] lf_rdata;

    tpmq_ram #(.WIDTH($bits(tpmq_pkg::t_node)), .DEPTH(tpmq_pkg::MAX_NODES)) u_node_ram (
        .i_clk(i_clk), .i_we(nd_we), .i_waddr(nd_waddr), .i_wdata(nd_wdata),
        .i_raddr(nd_raddr), .o_rdata(nd_rdata)
    );

    tpmq_ram #(.WIDTH($bits(tpmq_pkg::t_lift)), .DEPTH(tpmq_pkg::LIFT_DEPTH)) u_lift_ram (
        .i_clk(i_clk), .i_we(lf_we), .i_waddr(lf_waddr), .i_wdata(lf_wdata),
        .i_raddr(lf_raddr), .o_rdata(lf_rdata)
    );

    assign nd_rd = tpmq_pkg::t_node'(nd_rdata);
    assign lf_rd = tpmq_pkg::t_lift'(lf_rdata);

    // shared conditions
    logic [CW-1:0] ld_child;
    logic          ld_good, ld_over, ld_last, clr_done, q_err, q_same;
    logic          lc_diff, out_free, in_fire;

    assign ld_child = {1'b0, r_edges} + CW'(1);
    assign ld_over  = ld_child >= r_nc;
    assign ld_good  = ({1'b0, r_item.parent_node} < r_nc)
                   && ({1'b0, r_item.parent_node} != ld_child);
    assign ld_last  = ld_child == (r_nc - CW'(1));
    assign clr_done = {1'b0, r_cnt} == (r_nc - CW'(1));
    assign q_err    = !r_ready || r_bad || ({1'b0, i_in_data.first_node} >= r_nc)
                   || ({1'b0, i_in_data.second_node} >= r_nc);
    assign q_same   = i_in_data.first_node == i_in_data.second_node;
    assign lc_diff  = r_tmp.anc != lf_rd.anc;
    assign out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == tpmq_pkg::S_IDLE) && !i_cfg_we;
    assign in_fire  = i_in_valid && o_in_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tpmq_pkg::S_CLEAR: begin
                if (clr_done) begin
                    n_state = r_pend ? tpmq_pkg::S_LD_P : tpmq_pkg::S_IDLE;
                end
            end
            tpmq_pkg::S_IDLE: begin
                if (in_fire) begin
                    if (i_in_data.op == tpmq_pkg::OP_LOAD) begin
                        n_state = r_ready ? tpmq_pkg::S_CLEAR : tpmq_pkg::S_LD_P;
                    end else if (q_err || q_same) begin
                        n_state = tpmq_pkg::S_RES;
                    end else begin
                        n_state = tpmq_pkg::S_Q_RA;
                    end
                end
            end
            tpmq_pkg::S_LD_P: n_state = ld_over ? tpmq_pkg::S_IDLE : tpmq_pkg::S_LD_C;
            tpmq_pkg::S_LD_C: n_state = tpmq_pkg::S_LD_W;
            tpmq_pkg::S_LD_W: begin
                if (ld_good) begin
                    n_state = tpmq_pkg::S_LD_L;
                end else begin
                    n_state = ld_last ? tpmq_pkg::S_BR : tpmq_pkg::S_IDLE;
                end
            end
            tpmq_pkg::S_LD_L:  n_state = r_last ? tpmq_pkg::S_BR : tpmq_pkg::S_IDLE;
            tpmq_pkg::S_BR:    n_state = tpmq_pkg::S_EN_RD;
            tpmq_pkg::S_EN_RD: n_state = tpmq_pkg::S_EN_WB;
            tpmq_pkg::S_EN_WB: n_state = tpmq_pkg::S_LV_RD;
            tpmq_pkg::S_LV_RD: n_state = tpmq_pkg::S_LV_WR;
            tpmq_pkg::S_LV_WR: begin
                n_state = (r_k == KW'(tpmq_pkg::LEVELS - 1)) ? tpmq_pkg::S_WCHK
                                                             : tpmq_pkg::S_LV_RD;
            end
            tpmq_pkg::S_WCHK: begin
                n_state = (r_cw.first_child != '0) ? tpmq_pkg::S_EN_RD : tpmq_pkg::S_CL;
            end
            tpmq_pkg::S_CL: begin
                if (r_cur == '0) begin
                    n_state = tpmq_pkg::S_FIN;
                end else if (r_cw.next_sibling != '0) begin
                    n_state = tpmq_pkg::S_EN_RD;
                end else begin
                    n_state = tpmq_pkg::S_UP;
                end
            end
            tpmq_pkg::S_UP:    n_state = tpmq_pkg::S_CL;
            tpmq_pkg::S_FIN:   n_state = tpmq_pkg::S_IDLE;
            tpmq_pkg::S_Q_RA:  n_state = tpmq_pkg::S_Q_RB;
            tpmq_pkg::S_Q_RB:  n_state = tpmq_pkg::S_Q_SW;
            tpmq_pkg::S_Q_SW:  n_state = tpmq_pkg::S_EQ_CK;
            tpmq_pkg::S_EQ_CK: begin
                if (r_da != r_db) begin
                    n_state = tpmq_pkg::S_EQ_UP;
                end else if (r_a == r_b) begin
                    n_state = tpmq_pkg::S_RES;
                end else begin
                    n_state = tpmq_pkg::S_LC_RA;
                end
            end
            tpmq_pkg::S_EQ_UP: n_state = tpmq_pkg::S_EQ_CK;
            tpmq_pkg::S_LC_RA: n_state = tpmq_pkg::S_LC_RB;
            tpmq_pkg::S_LC_RB: n_state = tpmq_pkg::S_LC_UP;
            tpmq_pkg::S_LC_UP: begin
                n_state = (!lc_diff && r_k == '0) ? tpmq_pkg::S_RES : tpmq_pkg::S_LC_RA;
            end
            tpmq_pkg::S_RES: n_state = out_free ? tpmq_pkg::S_IDLE : tpmq_pkg::S_RES;
            default:         n_state = tpmq_pkg::S_IDLE;
        endcase
        if (i_cfg_we) begin
            n_state = tpmq_pkg::S_CLEAR;
        end
    end

    // datapath and memory controls
    always_comb begin
        n_nc = r_nc;       n_edges = r_edges; n_ready = r_ready; n_bad = r_bad;
        n_pend = r_pend;   n_last = r_last;   n_cnt = r_cnt;     n_item = r_item;
        n_pword = r_pword; n_cw = r_cw;       n_tmp = r_tmp;     n_cur = r_cur;
        n_v = r_v;         n_par = r_par;     n_d = r_d;         n_root = r_root;
        n_anc = r_anc;     n_mn = r_mn;       n_k = r_k;         n_seen = r_seen;
        n_a = r_a;         n_b = r_b;         n_da = r_da;       n_db = r_db;
        n_ans = r_ans;     n_fnone = r_fnone; n_ferr = r_ferr;   n_out = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        nd_we = 1'b0; nd_waddr = '0; nd_wdata = '0; nd_raddr = '0;
        lf_we = 1'b0; lf_waddr = '0; lf_wdata = '0; lf_raddr = '0;

        case (r_state)
            tpmq_pkg::S_CLEAR: begin
                nd_we    = 1'b1;
                nd_waddr = r_cnt;
                n_cnt    = r_cnt + NW'(1);
            end
            tpmq_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_item = i_in_data;
                    if (i_in_data.op == tpmq_pkg::OP_LOAD) begin
                        if (r_ready) begin
                            // restart: a new tree begins with this edge
                            n_edges = '0; n_ready = 1'b0; n_bad = 1'b0;
                            n_cnt = '0;   n_pend = 1'b1;
                        end
                    end else begin
                        n_ans   = tpmq_pkg::INT_MAX;
                        n_ferr  = q_err;
                        n_fnone = !q_err && q_same;
                    end
                end
            end
            tpmq_pkg::S_LD_P: begin
                n_pend   = 1'b0;
                nd_raddr = r_item.parent_node;
            end
            tpmq_pkg::S_LD_C: begin
                n_pword  = nd_rd;
                nd_raddr = ld_child[NW-1:0];
            end
            tpmq_pkg::S_LD_W: begin
                nd_we    = 1'b1;
                nd_waddr = ld_child[NW-1:0];
                nd_wdata = '{parent: r_item.parent_node, weight: r_item.edge_weight,
                             first_child: nd_rd.first_child,
                             next_sibling: ld_good ? r_pword.first_child : '0,
                             depth: nd_rd.depth};
                if (!ld_good) begin
                    n_bad = 1'b1;
                end
                n_edges = ld_child[NW-1:0];
                n_last  = ld_last;
            end
            tpmq_pkg::S_LD_L: begin
                // link the new child at the head of its parent's list
                nd_we    = 1'b1;
                nd_waddr = r_item.parent_node;
                nd_wdata = r_pword;
                nd_wdata.first_child = {1'b0, r_edges};
            end
            tpmq_pkg::S_BR: begin
                n_v = '0; n_par = '0; n_d = '0; n_root = 1'b1; n_seen = '0;
            end
            tpmq_pkg::S_EN_RD: begin
                nd_raddr = r_v;
            end
            tpmq_pkg::S_EN_WB: begin
                nd_we    = 1'b1;
                nd_waddr = r_v;
                nd_wdata = nd_rd;
                nd_wdata.parent = r_par;
                nd_wdata.depth  = r_d;
                n_cw     = nd_wdata;
                lf_we    = 1'b1;
                lf_waddr = tpmq_pkg::lift_addr(r_v, '0);
                lf_wdata.anc = r_par;
                lf_wdata.mn  = r_root ? tpmq_pkg::INT_MAX : nd_rd.weight;
                n_anc  = r_par;
                n_mn   = lf_wdata.mn;
                n_k    = KW'(1);
                n_cur  = r_v;
                n_root = 1'b0;
                n_seen = r_seen + CW'(1);
            end
            tpmq_pkg::S_LV_RD: begin
                lf_raddr = tpmq_pkg::lift_addr(r_anc, r_k - KW'(1));
            end
            tpmq_pkg::S_LV_WR: begin
                lf_we    = 1'b1;
                lf_waddr = tpmq_pkg::lift_addr(r_v, r_k);
                lf_wdata.anc = lf_rd.anc;
                lf_wdata.mn  = tpmq_pkg::smin(r_mn, lf_rd.mn);
                n_anc = lf_wdata.anc;
                n_mn  = lf_wdata.mn;
                n_k   = r_k + KW'(1);
            end
            tpmq_pkg::S_WCHK: begin
                if (r_cw.first_child != '0) begin
                    n_v   = r_cw.first_child[NW-1:0];
                    n_par = r_cur;
                    n_d   = r_cw.depth + NW'(1);
                end
            end
            tpmq_pkg::S_CL: begin
                if (r_cur != '0 && r_cw.next_sibling != '0) begin
                    // a sibling sits at the same depth as this node
                    n_v   = r_cw.next_sibling[NW-1:0];
                    n_par = r_cw.parent;
                    n_d   = r_cw.depth;
                end
                nd_raddr = r_cw.parent;
            end
            tpmq_pkg::S_UP: begin
                n_cw  = nd_rd;
                n_cur = r_cw.parent;
            end
            tpmq_pkg::S_FIN: begin
                n_ready = 1'b1;
                if (r_seen < r_nc) begin
                    n_bad = 1'b1;
                end
            end
            tpmq_pkg::S_Q_RA: begin
                nd_raddr = r_item.first_node;
                n_a = r_item.first_node;
                n_b = r_item.second_node;
            end
            tpmq_pkg::S_Q_RB: begin
                n_da     = nd_rd.depth;
                nd_raddr = r_b;
            end
            tpmq_pkg::S_Q_SW: begin
                if (r_da < nd_rd.depth) begin
                    n_a = r_b; n_b = r_a; n_da = nd_rd.depth; n_db = r_da;
                end else begin
                    n_db = nd_rd.depth;
                end
            end
            tpmq_pkg::S_EQ_CK: begin
                if (r_da != r_db) begin
                    n_k      = tpmq_pkg::top_bit(r_da - r_db);
                    lf_raddr = tpmq_pkg::lift_addr(r_a, n_k);
                end else begin
                    n_k = KW'(tpmq_pkg::LEVELS - 1);
                end
            end
            tpmq_pkg::S_EQ_UP: begin
                n_ans = tpmq_pkg::smin(r_ans, lf_rd.mn);
                n_a   = lf_rd.anc;
                n_da  = r_da - (NW'(1) << r_k);
            end
            tpmq_pkg::S_LC_RA: begin
                lf_raddr = tpmq_pkg::lift_addr(r_a, r_k);
            end
            tpmq_pkg::S_LC_RB: begin
                n_tmp    = lf_rd;
                lf_raddr = tpmq_pkg::lift_addr(r_b, r_k);
            end
            tpmq_pkg::S_LC_UP: begin
                if (lc_diff) begin
                    // jump both; at level zero stay for the final parent step
                    n_ans = tpmq_pkg::smin(r_ans, tpmq_pkg::smin(r_tmp.mn, lf_rd.mn));
                    n_a   = r_tmp.anc;
                    n_b   = lf_rd.anc;
                    if (r_k != '0) begin
                        n_k = r_k - KW'(1);
                    end
                end else if (r_k == '0) begin
                    n_ans = tpmq_pkg::smin(r_ans, tpmq_pkg::smin(r_tmp.mn, lf_rd.mn));
                end else begin
                    n_k = r_k - KW'(1);
                end
            end
            tpmq_pkg::S_RES: begin
                if (out_free) begin
                    n_out       = '{path_min: r_ans, no_edge: r_fnone, error: r_ferr};
                    n_out_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (i_cfg_we) begin
            n_nc    = tpmq_pkg::clamp_count(i_cfg_data);
            n_edges = '0; n_ready = 1'b0; n_bad = 1'b0;
            n_cnt   = '0; n_pend = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tpmq_pkg::S_CLEAR;
            r_nc        <= CW'(2);
            r_edges     <= '0;
            r_ready     <= 1'b0;
            r_bad       <= 1'b0;
            r_pend      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_nc        <= n_nc;
            r_edges     <= n_edges;
            r_ready     <= n_ready;
            r_bad       <= n_bad;
            r_pend      <= n_pend;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last  <= n_last;  r_item <= n_item; r_pword <= n_pword; r_cw <= n_cw;
        r_tmp   <= n_tmp;   r_cur  <= n_cur;  r_v     <= n_v;     r_par <= n_par;
        r_d     <= n_d;     r_root <= n_root; r_anc   <= n_anc;   r_mn  <= n_mn;
        r_k     <= n_k;     r_seen <= n_seen; r_a     <= n_a;     r_b   <= n_b;
        r_da    <= n_da;    r_db   <= n_db;   r_ans   <= n_ans;   r_fnone <= n_fnone;
        r_ferr  <= n_ferr;  r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule

/* tb/sv/tb_top.sv */
// Self-checking bench for tree_path_minimum_query: random trees, path-minimum answers.
// Results are predicted by a scoreboard class that walks parent pointers.
// Depends on tpmq_pkg and the top level of the block.
module tb_top;

    class path_min_scoreboard;
        int unsigned        node_cnt;
        int unsigned        parent_idx [tpmq_pkg::MAX_NODES];
        logic signed [31:0] edge_wt [tpmq_pkg::MAX_NODES];
        int unsigned        level_of [tpmq_pkg::MAX_NODES];
        int unsigned        edges_in;
        bit                 ready;
        bit                 broken;
        tpmq_pkg::t_out     expected_results [$];
        int                 fails;
        int                 items_taken;
        int                 results_checked;

        function void restart();
            edges_in = 0;
            ready    = 0;
            broken   = 0;
        endfunction

        function void set_count(int unsigned v);
            v = v & 11'h7ff;
            node_cnt = (v < 2) ? 2 : (v > tpmq_pkg::MAX_NODES) ? tpmq_pkg::MAX_NODES : v;
            restart();
        endfunction

        // Finish a tree: every node must reach the root; record levels on the way.
        function void finish_tree();
            int unsigned u;
            int unsigned steps;
            ready = 1;
            if (broken) begin
                return;
            end
            level_of[0] = 0;
            for (int unsigned v = 1; v < node_cnt; v++) begin
                u     = v;
                steps = 0;
                while (u != 0 && steps < node_cnt) begin
                    u = parent_idx[u];
                    steps++;
                end
                if (u != 0) begin
                    broken = 1;
                    return;
                end
                level_of[v] = steps;
            end
        endfunction

        function logic signed [31:0] walk_min(int unsigned a, int unsigned b);
            logic signed [31:0] m;
            m = tpmq_pkg::INT_MAX;
            while (level_of[a] > level_of[b]) begin
                if (edge_wt[a] < m) m = edge_wt[a];
                a = parent_idx[a];
            end
            while (level_of[b] > level_of[a]) begin
                if (edge_wt[b] < m) m = edge_wt[b];
                b = parent_idx[b];
            end
            while (a != b) begin
                if (edge_wt[a] < m) m = edge_wt[a];
                if (edge_wt[b] < m) m = edge_wt[b];
                a = parent_idx[a];
                b = parent_idx[b];
            end
            return m;
        endfunction

        function void note_item(tpmq_pkg::t_in it);
            int unsigned    child;
            tpmq_pkg::t_out res;
            items_taken++;
            if (it.op == tpmq_pkg::OP_LOAD) begin
                if (ready) restart();
                child = edges_in + 1;
                if (child >= node_cnt) return;
                parent_idx[child] = 32'(it.parent_node);
                edge_wt[child]    = it.edge_weight;
                if (it.parent_node >= node_cnt || it.parent_node == child) broken = 1;
                edges_in = child;
                if (edges_in == node_cnt - 1) finish_tree();
                return;
            end
            res.path_min = tpmq_pkg::INT_MAX;
            res.no_edge  = 0;
            res.error    = 0;
            if (!ready || broken || it.first_node >= node_cnt || it.second_node >= node_cnt) begin
                res.error = 1;
            end else if (it.first_node == it.second_node) begin
                res.no_edge = 1;
            end else begin
                res.path_min = walk_min(32'(it.first_node), 32'(it.second_node));
            end
            expected_results.insert(expected_results.size(), res);
        endfunction

        function void check_result(tpmq_pkg::t_out got);
            tpmq_pkg::t_out want;
            results_checked++;
            if (expected_results.size() == 0) begin
                $error("unexpected result: path_min %0d no_edge %0b error %0b",
                       got.path_min, got.no_edge, got.error);
                fails++;
                return;
            end
            want = expected_results.pop_front();
            if (got.path_min !== want.path_min) begin
                $error("path_min: expected %0d, got %0d", want.path_min, got.path_min);
                fails++;
            end
            if (got.no_edge !== want.no_edge) begin
                $error("no_edge: expected %0b, got %0b", want.no_edge, got.no_edge);
                fails++;
            end
            if (got.error !== want.error) begin
                $error("error: expected %0b, got %0b", want.error, got.error);
                fails++;
            end
        endfunction
    endclass

    logic  i_clk = 0;
    logic  i_rst_n = 0;
    logic  cfg_we = 0;
    logic  [10:0] cfg_data = '0;
    logic  in_valid = 0;
    logic  in_ready;
    tpmq_pkg::t_in  in_data = '0;
    logic  out_valid;
    logic  out_ready = 0;
    tpmq_pkg::t_out out_data;
    bit    quiet = 0;

    path_min_scoreboard sb = new();

    tree_path_minimum_query dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #5 i_clk = ~i_clk;

    task automatic send_item(tpmq_pkg::t_in it);
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        sb.note_item(it);
    endtask

    task automatic load_edge(int unsigned p, logic signed [31:0] w);
        tpmq_pkg::t_in it;
        it             = '0;
        it.op          = tpmq_pkg::OP_LOAD;
        it.parent_node = p[tpmq_pkg::NODE_W-1:0];
        it.edge_weight = w;
        send_item(it);
    endtask

    task automatic ask(int unsigned a, int unsigned b);
        tpmq_pkg::t_in it;
        it             = '0;
        it.op          = tpmq_pkg::OP_QUERY;
        it.first_node  = a[tpmq_pkg::NODE_W-1:0];
        it.second_node = b[tpmq_pkg::NODE_W-1:0];
        send_item(it);
    endtask

    // Drop valid and hold until every expected result has arrived.
    task automatic drain_results();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_count(int unsigned v);
        drain_results();
        // a final load may still be walking the tree
        repeat (28 * sb.node_cnt + 64) @(posedge i_clk);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= v[10:0];
        sb.set_count(v);
        @(negedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    // shape: 0 random, 1 chain, 2 possibly broken
    task automatic load_tree(int shape);
        int unsigned n;
        int unsigned p;
        int unsigned mid_ask;
        n       = sb.node_cnt;
        mid_ask = $urandom_range(1, 4 * n);
        for (int unsigned c = 1; c < n; c++) begin
            case (shape)
                0: p = $urandom_range(0, c - 1);
                1: p = c - 1;
                default: begin
                    if ($urandom_range(0, 1)) p = $urandom_range(0, 1023);
                    else p = $urandom_range(0, n - 1);
                end
            endcase
            load_edge(p, $urandom);
            if (c == mid_ask) ask($urandom_range(0, n - 1), $urandom_range(0, 1023));
        end
    endtask

    task automatic random_asks(int unsigned k);
        int unsigned a;
        int unsigned b;
        for (int unsigned i = 0; i < k; i++) begin
            a = $urandom_range(0, sb.node_cnt - 1);
            b = $urandom_range(0, 5) == 0 ? a : $urandom_range(0, sb.node_cnt - 1);
            if ($urandom_range(0, 7) == 0) a = $urandom_range(0, 1023);
            if ($urandom_range(0, 7) == 0) b = $urandom_range(0, 1023);
            ask(a, b);
        end
    endtask

    // receiver: random stalls, one long hold-off
    initial begin
        int unsigned idle_left;
        bit          held;
        idle_left = 0;
        held      = 0;
        forever begin
            @(posedge i_clk);
            if (out_valid && out_ready) sb.check_result(out_data);
            @(negedge i_clk);
            if (!held && sb.results_checked >= 4) begin
                held      = 1;
                idle_left = 400;
            end
            if (idle_left == 0 && !quiet && $urandom_range(0, 4) == 0) begin
                idle_left = $urandom_range(1, 13);
            end
            out_ready <= (idle_left == 0);
            if (idle_left != 0) idle_left--;
        end
    end

    initial begin
        #20000000;
        $display("tree_path_minimum_query test failed");
        $finish;
    end

    initial begin
        int unsigned shape_pick;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        sb.set_count(2);

        // directed: two-, three- and four-node trees, extremes and special cases
        write_count(0);
        ask(0, 1);
        load_edge(0, 32'sh8000_0000);
        ask(0, 1);
        ask(1, 0);
        ask(0, 0);
        ask(1, 1);
        ask(2, 0);
        ask(1023, 1023);
        load_edge(1, 32'sh7fff_ffff);
        ask(0, 1);
        load_edge(1023, 0);
        ask(1, 0);
        write_count(1);
        write_count(3);
        load_edge(0, tpmq_pkg::INT_MAX);
        ask(2, 1);
        load_edge(1, 5);
        ask(2, 0);
        ask(1, 2);
        ask(0, 2);
        // parent cycle between nodes 1 and 2
        write_count(4);
        load_edge(2, -7);
        load_edge(1, 3);
        load_edge(0, 9);
        ask(0, 3);

        // random trees, mostly small
        while (sb.items_taken < 90) begin
            if ($urandom_range(0, 9) == 0) write_count($urandom_range(41, 200));
            else write_count($urandom_range(2, 40));
            repeat ($urandom_range(1, 2)) begin
                shape_pick = $urandom_range(0, 99);
                load_tree(shape_pick < 70 ? 0 : shape_pick < 85 ? 1 : 2);
                random_asks($urandom_range(5, 20));
                if ($urandom_range(0, 3) == 0) drain_results();
            end
        end

        // last part: largest tree as a chain, no idling
        quiet = 1;
        write_count(2047);
        load_tree(1);
        random_asks(30);
        ask(0, 1023);
        ask(1023, 1);

        drain_results();
        repeat (200) @(posedge i_clk);
        if (sb.fails == 0 && sb.expected_results.size() == 0) begin
            $display("tree_path_minimum_query test passed");
        end else begin
            $display("tree_path_minimum_query test failed");
        end
        $finish;
    end
endmodule

/* filelist.f */
design/tpmq_pkg.sv
design/tpmq_ram.sv
design/tree_path_minimum_query.sv
tb/sv/tb_top.sv
